[design/b64sc_pkg.sv]
// Package for the base64 stream codec: word types, queue entry type and
// the alphabet and character classification functions. No dependencies.
package b64sc_pkg;

  localparam int unsigned B64SC_FIFO_DEPTH = 2;
  localparam logic [7:0]  PAD_CHAR         = 8'h3D;
  localparam int unsigned MAX_DATA         = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       error;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [2:0]               ndata;
    logic                     status;
    logic                     err;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_SKIP,
    CLS_PAD,
    CLS_BAD
  } cls_kind_t;

  typedef struct packed {
    cls_kind_t  kind;
    logic [5:0] val;
  } cls_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return w + 8'h41;
    else if (v < 6'd52) return w + 8'h47;
    else if (v < 6'd62) return w + 8'hFC;
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  function automatic cls_t classify(input logic [7:0] ch);
    cls_t c;
    c.kind = CLS_BAD;
    c.val  = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      c.kind = CLS_DATA;
      c.val  = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      c.kind = CLS_DATA;
      c.val  = 6'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      c.kind = CLS_DATA;
      c.val  = 6'(ch + 8'h04);
    end else if (ch == 8'h2B) begin
      c.kind = CLS_DATA;
      c.val  = 6'd62;
    end else if (ch == 8'h2F) begin
      c.kind = CLS_DATA;
      c.val  = 6'd63;
    end else if (ch == PAD_CHAR) begin
      c.kind = CLS_PAD;
    end else if ((ch >= 8'd9 && ch <= 8'd13) || ch == 8'd32) begin
      c.kind = CLS_SKIP;
    end
    return c;
  endfunction

endpackage

[design/b64sc_front.sv]
// Front end of the base64 stream codec: mode register, codec state and
// translation of each input word into a job for the queue. Uses b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  in_word_t   in_data,
  input  logic       in_acc,
  output logic       push,
  output job_t       job
);

  logic        mode_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  pads_r, pads_nxt;
  logic        err_r, err_nxt;

  always_comb begin
    logic [7:0] b, b0, b1;
    logic [1:0] ph, pc;
    logic [15:0] hb;
    logic es;
    cls_t cl;
    b  = in_data.data_byte;
    b0 = 8'h00;
    b1 = 8'h00;
    ph = phase_r;
    hb = held_r;
    pc = pads_r;
    es = err_r;
    cl = classify(b);
    job = '0;
    if (in_data.has_byte) begin
      if (!mode_r) begin
        unique case (ph)
          2'd0: begin
            hb = {b, 8'h00};
            ph = 2'd1;
          end
          2'd1: begin
            hb = {hb[15:8], b};
            ph = 2'd2;
          end
          default: begin
            job.data[0] = sym(hb[15:10]);
            job.data[1] = sym({hb[9:8], hb[7:4]});
            job.data[2] = sym({hb[3:0], b[7:6]});
            job.data[3] = sym(b[5:0]);
            job.ndata   = 3'd4;
            hb = '0;
            ph = 2'd0;
          end
        endcase
      end else if (!es) begin
        priority if (cl.kind == CLS_SKIP) begin
          es = 1'b0;
        end else if (cl.kind == CLS_PAD && pc < 2'd2) begin
          pc = pc + 2'd1;
        end else if (cl.kind != CLS_DATA || pc != 2'd0) begin
          es = 1'b1;
        end else begin
          unique case (ph)
            2'd0: hb = {8'h00, cl.val, 2'b00};
            2'd1: begin
              job.data[0] = hb[7:0] | {6'b0, cl.val[5:4]};
              job.ndata   = 3'd1;
              hb = {8'h00, cl.val[3:0], 4'h0};
            end
            2'd2: begin
              job.data[0] = hb[7:0] | {4'h0, cl.val[5:2]};
              job.ndata   = 3'd1;
              hb = {8'h00, cl.val[1:0], 6'h00};
            end
            default: begin
              job.data[0] = hb[7:0] | {2'b00, cl.val};
              job.ndata   = 3'd1;
              hb = '0;
            end
          endcase
          ph = ph + 2'd1;
        end
      end
    end
    if (in_data.finish) begin
      b0 = hb[15:8];
      b1 = hb[7:0];
      job.status = 1'b1;
      job.err    = es;
      if (mode_r) begin
        if (2'(ph + pc) != 2'd0) job.err = 1'b1;
      end else if (ph == 2'd1) begin
        job.data[0] = sym(b0[7:2]);
        job.data[1] = sym({b0[1:0], 4'h0});
        job.data[2] = PAD_CHAR;
        job.data[3] = PAD_CHAR;
        job.ndata   = 3'd4;
      end else if (ph != 2'd0) begin
        job.data[0] = sym(b0[7:2]);
        job.data[1] = sym({b0[1:0], b1[7:4]});
        job.data[2] = sym({b1[3:0], 2'b00});
        job.data[3] = PAD_CHAR;
        job.ndata   = 3'd4;
      end
      ph = '0;
      hb = '0;
      pc = '0;
      es = 1'b0;
    end
    phase_nxt = ph;
    held_nxt  = hb;
    pads_nxt  = pc;
    err_nxt   = es;
    push = in_acc && (job.ndata != 3'd0 || job.status);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= '0;
      held_r  <= '0;
      pads_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (in_acc) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        pads_r  <= pads_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

[design/b64sc_fifo.sv]
// Short job queue between the front end and the back end of the base64
// stream codec. Uses b64sc_pkg.
module b64sc_fifo import b64sc_pkg::*; #(
  parameter int unsigned DEPTH = B64SC_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       wr_job,
  input  logic       pop,
  output job_t       rd_job,
  output fifo_stat_t stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) return '0;
    return p + PW'(1);
  endfunction

  assign rd_job     = mem_r[rp_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop) rp_r <= bump(rp_r);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[design/b64sc_back.sv]
// Back end of the base64 stream codec: takes jobs from the queue and
// sends their result words through an output register, one per cycle
// unless stalled. Uses b64sc_pkg.
module b64sc_back import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       rd_job,
  input  fifo_stat_t stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  job_t       job_r, job_nxt;
  logic       jv_r, jv_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  out_word_t  od_r, od_nxt;

  logic       adv, emit, last;
  logic [2:0] total;

  always_comb begin
    total = job_r.ndata + {2'b00, job_r.status};
    adv   = !ov_r || !out_stall;
    emit  = jv_r && adv;
    last  = (idx_r == total - 3'd1);
    pop   = !stat.empty && (!jv_r || (emit && last));

    job_nxt = job_r;
    jv_nxt  = jv_r;
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;

    if (emit) begin
      ov_nxt = 1'b1;
      if (idx_r < job_r.ndata) begin
        od_nxt.out_byte  = job_r.data[idx_r[1:0]];
        od_nxt.is_status = 1'b0;
        od_nxt.error     = 1'b0;
      end else begin
        od_nxt.out_byte  = 8'h00;
        od_nxt.is_status = 1'b1;
        od_nxt.error     = job_r.err;
      end
      od_nxt.last_of_run = last;
      idx_nxt = idx_r + 3'd1;
      if (last) jv_nxt = 1'b0;
    end else if (adv) begin
      ov_nxt = 1'b0;
    end

    if (pop) begin
      job_nxt = rd_job;
      jv_nxt  = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r  <= 1'b0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      jv_r  <= jv_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

[design/base64_stream_codec.sv]
// Base64 stream codec top level. An input word can be taken every cycle while
// the queue has room; its first result passes the queue and the job and output
// registers. Results leave at one per cycle unless stalled, so encoding
// sustains four characters per three bytes and decoding one word per cycle.
// Synchronous active-low reset selects encode mode and clears control state.
// Depends on b64sc_pkg, b64sc_front, b64sc_fifo and b64sc_back.
module base64_stream_codec import b64sc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = B64SC_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic       in_acc, push, pop;
  job_t       wr_job, rd_job;
  fifo_stat_t stat;

  assign in_stall = stat.full;
  assign in_acc   = in_valid && !in_stall;

  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .in_acc    (in_acc),
    .push      (push),
    .job       (wr_job)
  );

  b64sc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (stat)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_job    (rd_job),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("job popped from an empty queue");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue both full and empty");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

[sim/b64sc_tb_pkg.sv]
`timescale 1ns / 100ps
// Result tracker for the base64 stream codec bench: predicts the words each
// accepted input word causes and checks the codec's result words against them.
// Depends on b64sc_pkg for the word types, the class codes and PAD_CHAR.
package b64sc_tb_pkg;
  import b64sc_pkg::*;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  class b64_result_tracker;
    bit        decode_mode;
    bit [1:0]  phase;
    bit [15:0] held;
    bit [1:0]  pads;
    bit        err_seen;
    out_word_t pending_results[$];
    out_word_t run_words[$];
    int unsigned failures;
    int unsigned results_checked;

    function void set_mode(bit m);
      decode_mode = m;
    endfunction

    function bit [7:0] letter(bit [5:0] v);
      return B64_ALPHABET[v];
    endfunction

    function cls_kind_t char_kind(input bit [7:0] ch, output bit [5:0] v);
      v = 6'd0;
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[i] == ch) begin
          v = 6'(i);
          return CLS_DATA;
        end
      end
      if (ch == PAD_CHAR) return CLS_PAD;
      if ((ch >= 8'd9 && ch <= 8'd13) || ch == 8'd32) return CLS_SKIP;
      return CLS_BAD;
    endfunction

    function void add_word(bit [7:0] b, bit st = 1'b0, bit err = 1'b0);
      out_word_t r;
      r.out_byte    = b;
      r.is_status   = st;
      r.error       = err;
      r.last_of_run = 1'b0;
      run_words.push_back(r);
    endfunction

    function void encode_byte(bit [7:0] b);
      bit [7:0] b0;
      bit [7:0] b1;
      b0 = held[15:8];
      b1 = held[7:0];
      if (phase == 2'd0) begin
        held  = {b, 8'h00};
        phase = 2'd1;
      end else if (phase == 2'd1) begin
        held[7:0] = b;
        phase     = 2'd2;
      end else begin
        add_word(letter(b0[7:2]));
        add_word(letter({b0[1:0], b1[7:4]}));
        add_word(letter({b1[3:0], b[7:6]}));
        add_word(letter(b[5:0]));
        held  = 16'h0000;
        phase = 2'd0;
      end
    endfunction

    function void flush_group();
      bit [7:0] b0;
      bit [7:0] b1;
      b0 = held[15:8];
      b1 = held[7:0];
      if (phase == 2'd1) begin
        add_word(letter(b0[7:2]));
        add_word(letter({b0[1:0], 4'h0}));
        add_word(PAD_CHAR);
        add_word(PAD_CHAR);
      end else if (phase >= 2'd2) begin
        add_word(letter(b0[7:2]));
        add_word(letter({b0[1:0], b1[7:4]}));
        add_word(letter({b1[3:0], 2'b00}));
        add_word(PAD_CHAR);
      end
    endfunction

    function void decode_char(bit [7:0] ch);
      cls_kind_t kind;
      bit [5:0]  v;
      if (err_seen) return;
      kind = char_kind(ch, v);
      if (kind == CLS_SKIP) return;
      if (kind == CLS_PAD && pads < 2'd2) begin
        pads++;
        return;
      end
      if (kind != CLS_DATA || pads != 2'd0) begin
        err_seen = 1'b1;
        return;
      end
      case (phase)
        2'd0: held = {8'h00, v, 2'b00};
        2'd1: begin
          add_word(held[7:0] | {6'b0, v[5:4]});
          held = {8'h00, v[3:0], 4'h0};
        end
        2'd2: begin
          add_word(held[7:0] | {4'b0, v[5:2]});
          held = {8'h00, v[1:0], 6'b0};
        end
        default: begin
          add_word(held[7:0] | {2'b0, v});
          held = 16'h0000;
        end
      endcase
      phase++;
    endfunction

    function void note_word(in_word_t w);
      bit        err;
      out_word_t r;
      run_words.delete();
      if (w.has_byte) begin
        if (decode_mode) decode_char(w.data_byte);
        else encode_byte(w.data_byte);
      end
      if (w.finish) begin
        err = err_seen;
        if (decode_mode) begin
          if (2'(phase + pads) != 2'd0) err = 1'b1;
        end else begin
          flush_group();
        end
        add_word(8'h00, 1'b1, err);
        phase    = 2'd0;
        held     = 16'h0000;
        pads     = 2'd0;
        err_seen = 1'b0;
      end
      foreach (run_words[i]) begin
        r = run_words[i];
        r.last_of_run = (i == run_words.size() - 1);
        pending_results.push_back(r);
      end
    endfunction

    function bit field_differs(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b0;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b1;
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      bit        bad;
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word expected none, got %h", $time, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      bad = field_differs("out_byte", want.out_byte, got.out_byte)
          | field_differs("is_status", want.is_status, got.is_status)
          | field_differs("error", want.error, got.error)
          | field_differs("last_of_run", want.last_of_run, got.last_of_run);
      if (bad) failures++;
    endfunction
  endclass

endpackage

[sim/tb_base64_stream_codec.sv]
`timescale 1ns / 100ps
// Self-checking bench for base64_stream_codec: directed and random messages in
// both modes, with random stalls on both sides. Depends on b64sc_pkg, b64sc_tb_pkg.
module tb_base64_stream_codec;
  import b64sc_pkg::*;
  import b64sc_tb_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  b64_result_tracker tracker = new;

  bit          tx_quiet;
  bit          rx_quiet;
  bit          rx_long_hold;
  int unsigned hold_left;
  int unsigned words_sent;
  int unsigned messages;
  int unsigned mode_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_stream_codec i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
    if (w.has_byte || w.finish) words_sent++;
    if (w.finish) messages++;
  endtask

  task automatic put_item(input logic [7:0] b, input bit has, input bit fin);
    in_word_t w;
    w.data_byte = b;
    w.has_byte  = has;
    w.finish    = fin;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_decode_mode(input bit m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    tracker.set_mode(m);
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  task automatic encode_message();
    int unsigned len;
    bit          fin_joined;
    bit          left_open;
    len        = $urandom_range(0, 7);
    fin_joined = $urandom_range(0, 1);
    left_open  = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) put_item(8'($urandom), 1'b0, 1'b0);
      put_item(8'($urandom), 1'b1, !left_open && fin_joined && i == len - 1);
    end
    if (!left_open && (!fin_joined || len == 0)) put_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic decode_message();
    bit [7:0]    text[$];
    int unsigned rem;
    int unsigned sp;
    bit          fin_joined;
    bit          left_open;
    repeat (4 * $urandom_range(0, 2)) text.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
    rem = $urandom_range(0, 2);
    if (rem != 0) rem++;
    repeat (rem) text.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
    repeat ((4 - rem) % 4) text.push_back(PAD_CHAR);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: text.insert($urandom_range(0, text.size()), 8'($urandom));
        1: text.push_back(PAD_CHAR);
        default: if (text.size() != 0) text.delete($urandom_range(0, text.size() - 1));
      endcase
    end
    fin_joined = $urandom_range(0, 1);
    left_open  = ($urandom_range(0, 9) == 0);
    foreach (text[i]) begin
      if ($urandom_range(0, 7) == 0) begin
        sp = $urandom_range(8, 13);
        put_item(8'(sp == 8 ? 32 : sp), 1'b1, 1'b0);
      end
      put_item(text[i], 1'b1, !left_open && fin_joined && i == text.size() - 1);
    end
    if (!left_open && (!fin_joined || text.size() == 0)) put_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_result(out_data);
        hold_left = rx_quiet ? 0 : $urandom_range(0, 6);
      end
      if (rx_long_hold) begin
        hold_left    = 150;
        rx_long_hold = 1'b0;
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned base;
    int unsigned chunk;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encode: full group, one and two held bytes at finish, idle and bare finish.
    put_item(8'h00, 1'b1, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'h80, 1'b1, 1'b0);
    put_item(8'h01, 1'b1, 1'b1);
    put_item(8'hFE, 1'b1, 1'b0);
    put_item(8'h7F, 1'b1, 1'b0);
    put_item(8'h00, 1'b0, 1'b1);
    put_item(8'hFF, 1'b0, 1'b0);
    put_item(8'h00, 1'b0, 1'b1);
    put_item(8'h12, 1'b1, 1'b0);
    put_item(8'h34, 1'b1, 1'b0);

    // Switch to decode with two bytes still held; then pads, whitespace and errors.
    set_decode_mode(1'b1);
    put_item("Q", 1'b1, 1'b0);
    put_item("U", 1'b1, 1'b0);
    put_item(PAD_CHAR, 1'b1, 1'b0);
    put_item(8'd9, 1'b1, 1'b0);
    put_item(PAD_CHAR, 1'b1, 1'b0);
    put_item(PAD_CHAR, 1'b1, 1'b1);
    put_item("T", 1'b1, 1'b0);
    put_item("Q", 1'b1, 1'b0);
    put_item(PAD_CHAR, 1'b1, 1'b0);
    put_item("Q", 1'b1, 1'b1);
    put_item(8'hFF, 1'b1, 1'b0);
    put_item(8'd32, 1'b1, 1'b1);
    put_item("T", 1'b1, 1'b0);
    put_item("W", 1'b1, 1'b0);
    put_item("F", 1'b1, 1'b0);

    // Back to encode three characters into a decode group.
    set_decode_mode(1'b0);
    put_item(8'd13, 1'b0, 1'b1);

    base  = words_sent;
    chunk = 0;
    while (words_sent - base < 75) begin
      set_decode_mode(1'(chunk % 3 == 2 ? $urandom_range(0, 1) : chunk % 2));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (chunk == 0) begin
        tx_quiet     = 1'b1;
        rx_long_hold = 1'b1;
      end
      repeat ($urandom_range(2, 4)) begin
        if (tracker.decode_mode) decode_message();
        else encode_message();
      end
      chunk++;
    end
    wait_drained();

    $display("Run covered %0d words in %0d messages across %0d mode writes.",
             words_sent, messages, mode_writes);
    $display("Checked %0d result words, %0d mismatched.",
             tracker.results_checked, tracker.failures);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
